FILE: rtl/tlbl_pkg.sv
// shared types and codes for the translation buffer with lru ranks
package tlbl_pkg;

  // item action codes
  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  // controller states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;  // capture the input transfer
    logic exec;  // search, update slots and load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;  // result register empty or draining this cycle
  } status_t;

endpackage

FILE: rtl/tlbl_in_if.sv
// request channel: action, page and frame with valid/ready
interface tlbl_in_if #(
  parameter int PAGE_BITS  = 16,
  parameter int FRAME_BITS = 8
);
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [PAGE_BITS-1:0]  page;
  logic [FRAME_BITS-1:0] frame;

  modport source (output valid, output action, output page, output frame, input ready);
  modport sink   (input valid, input action, input page, input frame, output ready);
endinterface

FILE: rtl/tlbl_out_if.sv
// result channel: hit, frame and slot with valid/ready
interface tlbl_out_if #(
  parameter int FRAME_BITS = 8,
  parameter int SLOT_BITS  = 2
);
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [FRAME_BITS-1:0] frame_out;
  logic [SLOT_BITS-1:0]  slot;

  modport source (output valid, output hit, output frame_out, output slot, input ready);
  modport sink   (input valid, input hit, input frame_out, input slot, output ready);
endinterface

FILE: rtl/tlb_lookup_with_lru_unit.sv
// top level: fully associative translation buffer with true-lru replacement
//
//   channel   dir  signals                              transfer when
//   in_ch     in   action, page, frame                  valid && ready
//   out_ch    out  hit, frame_out, slot                 valid && ready
//
// each item is captured from the request, then executed: all slots are
// searched in parallel, tags, valid bits and ranks are updated, and the result
// register is loaded. in_ch.ready is high only while the controller is idle.
// the result register frees the request side: the next item is accepted
// while a result still waits; execute stalls only while it stays untaken.
// reset clears the valid bits, ranks, result valid flag and control state.
module tlb_lookup_with_lru_unit #(
  parameter int ENTRIES    = 4,
  parameter int PAGE_BITS  = 16,
  parameter int FRAME_BITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  tlbl_in_if.sink    in_ch,
  tlbl_out_if.source out_ch
);

  localparam int IDX_BITS = $clog2(ENTRIES);

  tlbl_pkg::cmd_t    cmd;
  tlbl_pkg::status_t status;

  logic                  in_ready;
  logic                  out_valid;
  logic                  out_hit;
  logic [FRAME_BITS-1:0] out_frame_out;
  logic [IDX_BITS-1:0]   out_slot;

  tlbl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tlbl_dp #(
    .ENTRIES    (ENTRIES),
    .PAGE_BITS  (PAGE_BITS),
    .FRAME_BITS (FRAME_BITS),
    .IDX_BITS   (IDX_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_action     (in_ch.action),
    .in_page       (in_ch.page),
    .in_frame      (in_ch.frame),
    .out_valid     (out_valid),
    .out_ready     (out_ch.ready),
    .out_hit       (out_hit),
    .out_frame_out (out_frame_out),
    .out_slot      (out_slot)
  );

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid;
  assign out_ch.hit       = out_hit;
  assign out_ch.frame_out = out_frame_out;
  assign out_ch.slot      = out_slot;

  // a request transfer is followed by the execute state, never directly by a second transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request accepted while previous item still executing");

  // execute never overwrites a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> (!out_ch.valid || out_ch.ready))
    else $error("result register overwritten before transfer");

  // every execute produces a result on the next cycle
  a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_ch.valid)
    else $error("execute did not present a result");

  // capture and execute never share a cycle
  a_load_exec_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.exec))
    else $error("capture and execute in the same cycle");

endmodule

FILE: rtl/tlbl_ctrl.sv
// controller: sequences capture and execute of one item at a time
module tlbl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tlbl_pkg::status_t status,
  output tlbl_pkg::cmd_t    cmd
);

  tlbl_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      tlbl_pkg::ST_IDLE: begin
        // no transfer while reset is held
        in_ready = rst_n;
        cmd.load = in_valid && rst_n;
        if (in_valid) begin
          state_nxt = tlbl_pkg::ST_EXEC;
        end
      end
      tlbl_pkg::ST_EXEC: begin
        // hold until the result register can take the new result
        cmd.exec = status.out_free;
        if (status.out_free) begin
          state_nxt = tlbl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tlbl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tlbl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/tlbl_dp.sv
// datapath: tag store, frame store, valid bits, lru ranks and result register
module tlbl_dp #(
  parameter int ENTRIES    = 4,
  parameter int PAGE_BITS  = 16,
  parameter int FRAME_BITS = 8,
  parameter int IDX_BITS   = $clog2(ENTRIES)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tlbl_pkg::cmd_t        cmd,
  output tlbl_pkg::status_t     status,
  input  logic                  in_action,
  input  logic [PAGE_BITS-1:0]  in_page,
  input  logic [FRAME_BITS-1:0] in_frame,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_hit,
  output logic [FRAME_BITS-1:0] out_frame_out,
  output logic [IDX_BITS-1:0]   out_slot
);

  localparam logic [IDX_BITS-1:0] TOP_RANK = IDX_BITS'(ENTRIES - 1);

  // captured request
  logic                  act_r;
  logic [PAGE_BITS-1:0]  page_r;
  logic [FRAME_BITS-1:0] frm_in_r;

  // slot state
  logic [PAGE_BITS-1:0]  tag_r  [ENTRIES];
  logic [FRAME_BITS-1:0] frm_r  [ENTRIES];
  logic [ENTRIES-1:0]    valid_r, valid_nxt;
  logic [IDX_BITS-1:0]   rank_r [ENTRIES];
  logic [IDX_BITS-1:0]   rank_nxt [ENTRIES];

  // result register
  logic                  out_valid_r;
  logic                  hit_r, hit_nxt;
  logic [FRAME_BITS-1:0] frame_out_r, frame_out_nxt;
  logic [IDX_BITS-1:0]   slot_r, slot_nxt;

  logic [ENTRIES-1:0]    match;
  logic [ENTRIES-1:0]    is_min;
  logic                  hit_any, free_any;
  logic [IDX_BITS-1:0]   hit_idx, free_idx, min_idx, victim;
  logic [IDX_BITS-1:0]   old_rank;

  // tag compare and lowest-rank test, each slot on its own
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = valid_r[i] && (tag_r[i] == page_r);
      is_min[i] = 1'b1;
      for (int j = 0; j < ENTRIES; j++) begin
        // ties go to the lowest-numbered slot
        if ((j < i) && (rank_r[j] <= rank_r[i])) begin
          is_min[i] = 1'b0;
        end
        if ((j > i) && (rank_r[j] < rank_r[i])) begin
          is_min[i] = 1'b0;
        end
      end
    end
  end

  // priority encoders, lowest slot wins
  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    min_idx  = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_any = 1'b1;
        hit_idx = IDX_BITS'(i);
      end
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = IDX_BITS'(i);
      end
      if (is_min[i]) begin
        min_idx = IDX_BITS'(i);
      end
    end
    victim   = free_any ? free_idx : min_idx;
    old_rank = rank_r[hit_idx];
  end

  // next slot state and result
  always_comb begin
    valid_nxt     = valid_r;
    rank_nxt      = rank_r;
    hit_nxt       = 1'b0;
    frame_out_nxt = '0;
    slot_nxt      = '0;
    if (act_r == tlbl_pkg::ACT_LOOKUP) begin
      if (hit_any) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_r[i] && (rank_r[i] > old_rank)) begin
            rank_nxt[i] = rank_r[i] - IDX_BITS'(1);
          end
        end
        rank_nxt[hit_idx] = TOP_RANK;
        hit_nxt           = 1'b1;
        frame_out_nxt     = frm_r[hit_idx];
        slot_nxt          = hit_idx;
      end
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        if ((IDX_BITS'(i) != victim) && valid_r[i] && (rank_r[i] != '0)) begin
          rank_nxt[i] = rank_r[i] - IDX_BITS'(1);
        end
      end
      rank_nxt[victim]  = TOP_RANK;
      valid_nxt[victim] = 1'b1;
      slot_nxt          = victim;
    end
  end

  assign status.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r    <= in_action;
      page_r   <= in_page;
      frm_in_r <= in_frame;
    end
    if (cmd.exec) begin
      hit_r       <= hit_nxt;
      frame_out_r <= frame_out_nxt;
      slot_r      <= slot_nxt;
      if (act_r == tlbl_pkg::ACT_INSERT) begin
        tag_r[victim] <= page_r;
        frm_r[victim] <= frm_in_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (cmd.exec) begin
        valid_r     <= valid_nxt;
        rank_r      <= rank_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hit       = hit_r;
  assign out_frame_out = frame_out_r;
  assign out_slot      = slot_r;

endmodule
